/* rtl/pfdrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types and constants for the packet buffer with duplicate check and
// range count.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int SRC_W     = 16;
	localparam int DST_W     = 16;
	localparam int TS_W      = 32;
	localparam int ENTRY_W   = SRC_W + DST_W + TS_W;
	localparam int LIM_W     = 7;
	localparam int CNT_W     = 7;
	localparam int OP_W      = 2;

	localparam logic [LIM_W-1:0] LIMIT_RST = 7'd64;
	localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_FWD = 2'd1;
	localparam logic [OP_W-1:0] OP_CNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic more;
	} ctrl_sts_t;

endpackage

/* rtl/pfdrc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfdrc_ram #(
	parameter int W = 64,
	parameter int D = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                   wdata,
	input  logic                           re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                   rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/pfdrc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_ctrl
// Sequencer: load command, scan the live entries (only the head for a forward), commit the result.
// ----------------------------------------------------------------------------
module pfdrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pfdrc_pkg::ctrl_sts_t  sts,
	output pfdrc_pkg::ctrl_cmd_t  cmd
);

	pfdrc_pkg::state_t state_q;
	pfdrc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfdrc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			pfdrc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = pfdrc_pkg::ST_SCAN;
				end
			end
			pfdrc_pkg::ST_SCAN: begin
				if (sts.more) begin
					cmd.rd = 1'b1;
				end else begin
					state_d = pfdrc_pkg::ST_FIN;
				end
			end
			pfdrc_pkg::ST_FIN: begin
				cmd.commit = 1'b1;
				state_d    = pfdrc_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfdrc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/pfdrc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_dp
// Datapath: packet store, ring pointers, scan compare and result registers.
// ----------------------------------------------------------------------------
module pfdrc_dp #(
	parameter int DEPTH = pfdrc_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfdrc_pkg::ctrl_cmd_t             cmd,
	output pfdrc_pkg::ctrl_sts_t             sts,
	input  logic [pfdrc_pkg::OP_W-1:0]       op,
	input  logic [pfdrc_pkg::SRC_W-1:0]      source,
	input  logic [pfdrc_pkg::DST_W-1:0]      dest,
	input  logic [pfdrc_pkg::TS_W-1:0]       stamp,
	input  logic [pfdrc_pkg::TS_W-1:0]       range_start,
	input  logic [pfdrc_pkg::TS_W-1:0]       range_end,
	input  logic                             cfg_we,
	input  logic [pfdrc_pkg::LIM_W-1:0]      cfg_wdata,
	output logic                             done,
	output logic                             accepted,
	output logic                             packet_valid,
	output logic [pfdrc_pkg::SRC_W-1:0]      out_source,
	output logic [pfdrc_pkg::DST_W-1:0]      out_dest,
	output logic [pfdrc_pkg::TS_W-1:0]       out_stamp,
	output logic [pfdrc_pkg::CNT_W-1:0]      match_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > pfdrc_pkg::LIM_W) ? CW : pfdrc_pkg::LIM_W;
	localparam int EW = pfdrc_pkg::ENTRY_W;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// latched command
	logic [pfdrc_pkg::OP_W-1:0]  op_q;
	logic [pfdrc_pkg::SRC_W-1:0] src_q;
	logic [pfdrc_pkg::DST_W-1:0] dst_q;
	logic [pfdrc_pkg::TS_W-1:0]  ts_q;
	logic [pfdrc_pkg::TS_W-1:0]  lo_q;
	logic [pfdrc_pkg::TS_W-1:0]  hi_q;

	// ring state
	logic [AW-1:0]               head_q;
	logic [CW-1:0]               occ_q;
	logic [pfdrc_pkg::LIM_W-1:0] limit_q;

	// scan state
	logic [AW-1:0]               rptr_q;
	logic [CW-1:0]               k_q;
	logic                        rd_v_s1;
	logic                        dup_q;
	logic [pfdrc_pkg::CNT_W-1:0] cnt_q;

	logic [EW-1:0]               rdata;
	logic [pfdrc_pkg::SRC_W-1:0] e_src;
	logic [pfdrc_pkg::DST_W-1:0] e_dst;
	logic [pfdrc_pkg::TS_W-1:0]  e_ts;
	logic                        hit_dup;
	logic                        hit_cnt;
	logic [LW-1:0]               eff_lim;
	logic                        at_lim;
	logic                        ram_we;

	assign e_src = rdata[EW-1 -: pfdrc_pkg::SRC_W];
	assign e_dst = rdata[pfdrc_pkg::TS_W +: pfdrc_pkg::DST_W];
	assign e_ts  = rdata[pfdrc_pkg::TS_W-1:0];

	assign hit_dup = (e_src == src_q) && (e_dst == dst_q) && (e_ts == ts_q);
	assign hit_cnt = (e_dst == dst_q) && (e_ts >= lo_q) && (e_ts <= hi_q);

	always_comb begin
		if (limit_q == '0) begin
			eff_lim = LW'(1);
		end else if (LW'(limit_q) > LW'(DEPTH)) begin
			eff_lim = LW'(DEPTH);
		end else begin
			eff_lim = LW'(limit_q);
		end
	end

	assign at_lim = LW'(occ_q) >= eff_lim;

	always_comb begin
		case (op_q)
			pfdrc_pkg::OP_ADD,
			pfdrc_pkg::OP_CNT: sts.more = k_q < occ_q;
			pfdrc_pkg::OP_FWD: sts.more = (k_q == '0) && (occ_q != '0);
			default:           sts.more = 1'b0;
		endcase
	end

	assign ram_we = cmd.commit && (op_q == pfdrc_pkg::OP_ADD) && !dup_q;

	pfdrc_ram #(
		.W (EW),
		.D (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rptr_q),
		.wdata ({src_q, dst_q, ts_q}),
		.re    (cmd.rd),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			src_q <= source;
			dst_q <= dest;
			ts_q  <= stamp;
			lo_q  <= range_start;
			hi_q  <= range_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			occ_q   <= '0;
			limit_q <= pfdrc_pkg::LIMIT_RST;
			rptr_q  <= '0;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
			dup_q   <= 1'b0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			rd_v_s1 <= cmd.rd;
			done    <= cmd.commit;
			if (cmd.load) begin
				rptr_q <= head_q;
				k_q    <= '0;
				dup_q  <= 1'b0;
				cnt_q  <= '0;
			end
			if (cmd.rd) begin
				rptr_q <= ptr_inc(rptr_q);
				k_q    <= k_q + 1'b1;
			end
			if (rd_v_s1) begin
				if ((op_q == pfdrc_pkg::OP_ADD) && hit_dup) begin
					dup_q <= 1'b1;
				end
				if ((op_q == pfdrc_pkg::OP_CNT) && hit_cnt && (cnt_q != pfdrc_pkg::CNT_MAX)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				case (op_q)
					pfdrc_pkg::OP_ADD: begin
						if (!dup_q) begin
							if (at_lim) begin
								head_q <= ptr_inc(head_q);
							end else begin
								occ_q <= occ_q + 1'b1;
							end
						end
					end
					pfdrc_pkg::OP_FWD: begin
						if (occ_q != '0) begin
							head_q <= ptr_inc(head_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted     <= 1'b0;
			packet_valid <= 1'b0;
			out_source   <= '0;
			out_dest     <= '0;
			out_stamp    <= '0;
			match_count  <= '0;
			case (op_q)
				pfdrc_pkg::OP_ADD: begin
					accepted <= !dup_q;
				end
				pfdrc_pkg::OP_FWD: begin
					if (occ_q != '0) begin
						packet_valid <= 1'b1;
						out_source   <= e_src;
						out_dest     <= e_dst;
						out_stamp    <= e_ts;
					end
				end
				pfdrc_pkg::OP_CNT: begin
					match_count <= cnt_q;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit))
		else $error("result beat without commit");

	a_add_no_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == pfdrc_pkg::OP_ADD) && !dup_q |=> occ_q >= $past(occ_q))
		else $error("accepted add reduced occupancy");

	a_fwd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && packet_valid |-> occ_q == CW'($past(occ_q) - 1'b1))
		else $error("forward did not pop one entry");
`endif

endmodule

/* rtl/packet_fifo_dedup_range_count_top.sv */
`timescale 1ns / 1ps
// A new command is taken only while idle; each is scanned through the packet
// store's single read port, one entry a cycle (only the head entry for a
// forward), before its commit and the done beat.
// The result beat is shown for one cycle; the receiver cannot stall it.
// arst_n clears pointers, occupancy and control; the limit resets to 64.
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_top
// Bounded packet buffer with duplicate rejection, forward and range count.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count_top #(
	parameter int DEPTH = pfdrc_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [pfdrc_pkg::OP_W-1:0]   op,
	input  logic [pfdrc_pkg::SRC_W-1:0]  source,
	input  logic [pfdrc_pkg::DST_W-1:0]  dest,
	input  logic [pfdrc_pkg::TS_W-1:0]   stamp,
	input  logic [pfdrc_pkg::TS_W-1:0]   range_start,
	input  logic [pfdrc_pkg::TS_W-1:0]   range_end,
	input  logic                         cfg_we,
	input  logic [pfdrc_pkg::LIM_W-1:0]  cfg_wdata,
	output logic                         done,
	output logic                         accepted,
	output logic                         packet_valid,
	output logic [pfdrc_pkg::SRC_W-1:0]  out_source,
	output logic [pfdrc_pkg::DST_W-1:0]  out_dest,
	output logic [pfdrc_pkg::TS_W-1:0]   out_stamp,
	output logic [pfdrc_pkg::CNT_W-1:0]  match_count
);

	pfdrc_pkg::ctrl_cmd_t cmd;
	pfdrc_pkg::ctrl_sts_t sts;

	pfdrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfdrc_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.source       (source),
		.dest         (dest),
		.stamp        (stamp),
		.range_start  (range_start),
		.range_end    (range_end),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.accepted     (accepted),
		.packet_valid (packet_valid),
		.out_source   (out_source),
		.out_dest     (out_dest),
		.out_stamp    (out_stamp),
		.match_count  (match_count)
	);

endmodule
